// ----- design/local_mean_variance_filter_core_assert.svh -----
// Assertion macros for the local mean/variance filter core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef LOCAL_MEAN_VARIANCE_FILTER_CORE_ASSERT_SVH
`define LOCAL_MEAN_VARIANCE_FILTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LMVF_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LMVF_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lmvf_pkg.sv -----
// Shared constants, widths and the queue entry type of the filter core.
// No dependencies.
`default_nettype none

package lmvf_pkg;

    localparam int MAX_COLS   = 2048;
    localparam int MAX_ROWS   = 2048;
    localparam int MAX_RADIUS = 15;
    localparam int SLOTS      = 2 * MAX_RADIUS + 1;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RWD   = $clog2(MAX_ROWS);
    localparam int SW    = $clog2(SLOTS);
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int KW    = RDW + 1;
    localparam int CFG_W = 12;
    localparam int AREA_W = $clog2(SLOTS * SLOTS + 1);

    localparam int CS_W = $clog2(SLOTS * 255 + 1);
    localparam int CQ_W = $clog2(SLOTS * 65025 + 1);
    localparam int WS_W = $clog2(SLOTS * SLOTS * 255 + 1);
    localparam int WQ_W = $clog2(SLOTS * SLOTS * 65025 + 1);
    localparam int MS_W = WS_W + 8;

    // variance is bounded by 16256 + 255 for 8-bit data
    localparam int VAR_W   = 15;
    localparam int ALPHA_W = 13;
    localparam int DEN_W   = 16;
    localparam int DIV_W0  = (WQ_W > MS_W) ? WQ_W : MS_W;
    localparam int DIV_W   = (DIV_W0 > 24) ? DIV_W0 : 24;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SMOOTH = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [3:0]       RST_RADIUS = 4'd2;
    localparam logic [4:0]       RST_SMOOTH = 5'd3;
    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

    typedef struct packed {
        logic [7:0]        pix;
        logic [CW-1:0]     col;
        logic [CW-1:0]     col_k;
        logic [CW-1:0]     col_r;
        logic [SW-1:0]     slot_old;
        logic [SW-1:0]     cslot;
        logic [AREA_W-1:0] area;
        logic              sub_old;
        logic              zero_col;
        logic              use_k;
        logic              first_col;
        logic              emit;
        logic [RWD-1:0]    out_row;
        logic              last;
    } t_item;

endpackage

`default_nettype wire

// ----- design/lmvf_front.sv -----
// Front part: tracks raster position, frame start and per-frame settings,
// and turns each pixel into a queue entry. Depends on lmvf_pkg.
`default_nettype none

module lmvf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_full,
    input  wire logic [7:0]                  i_pixel,
    input  wire logic                        i_frame_start,
    input  wire logic [3:0]                  i_radius,
    input  wire logic [lmvf_pkg::CFG_W-1:0]  i_width,
    input  wire logic [lmvf_pkg::CFG_W-1:0]  i_height,
    output logic                             o_push,
    output lmvf_pkg::t_item                  o_item
);
    import lmvf_pkg::*;

    logic [RWD-1:0]   r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [SW-1:0]    r_slot, n_slot;
    logic [RDW-1:0]   r_act_r;
    logic [CFG_W-1:0] r_act_w, r_act_h;

    logic             w_fs;
    logic [RDW-1:0]   w_rad_c, w_r;
    logic [CFG_W-1:0] w_wid_c, w_hgt_c, w_w, w_h;
    logic [RWD-1:0]   w_row;
    logic [CW-1:0]    w_col;
    logic [SW-1:0]    w_slot;
    logic [KW-1:0]    w_k;
    logic [31:0]      w_cs;

    always_comb begin
        w_fs = i_frame_start || (r_row == '0 && r_col == '0);

        if (i_radius == 4'd0)
            w_rad_c = RDW'(1);
        else if (32'(i_radius) > 32'(MAX_RADIUS))
            w_rad_c = RDW'(MAX_RADIUS);
        else
            w_rad_c = RDW'(i_radius);

        if (32'(i_width) < 32'd3)
            w_wid_c = CFG_W'(3);
        else if (32'(i_width) > 32'(MAX_COLS))
            w_wid_c = CFG_W'(MAX_COLS);
        else
            w_wid_c = i_width;

        if (32'(i_height) < 32'd3)
            w_hgt_c = CFG_W'(3);
        else if (32'(i_height) > 32'(MAX_ROWS))
            w_hgt_c = CFG_W'(MAX_ROWS);
        else
            w_hgt_c = i_height;

        w_r    = w_fs ? w_rad_c : r_act_r;
        w_w    = w_fs ? w_wid_c : r_act_w;
        w_h    = w_fs ? w_hgt_c : r_act_h;
        w_row  = w_fs ? '0 : r_row;
        w_col  = w_fs ? '0 : r_col;
        w_slot = w_fs ? '0 : r_slot;
        w_k    = KW'({w_r, 1'b1});

        o_push = i_valid && !i_full;

        o_item.pix       = i_pixel;
        o_item.col       = w_col;
        o_item.col_k     = CW'(32'(w_col) - 32'(w_k));
        o_item.col_r     = CW'(32'(w_col) - 32'(w_r));
        o_item.slot_old  = w_slot;
        // slot of the centre row, r rows back in the ring of k slots
        w_cs             = 32'(w_slot) + 32'(w_r) + 32'd1;
        o_item.cslot     = (w_cs >= 32'(w_k)) ? SW'(w_cs - 32'(w_k)) : SW'(w_cs);
        o_item.area      = AREA_W'(AREA_W'(w_k) * AREA_W'(w_k));
        o_item.sub_old   = 32'(w_row) >= 32'(w_k);
        o_item.zero_col  = w_row == '0;
        o_item.use_k     = 32'(w_col) >= 32'(w_k);
        o_item.first_col = w_col == '0;
        o_item.emit      = (32'(w_row) >= 32'(w_k) - 32'd1)
                        && (32'(w_col) >= 32'(w_k) - 32'd1);
        o_item.out_row   = RWD'(32'(w_row) - 32'(w_r));
        o_item.last      = (32'(w_row) + 32'd1 >= 32'(w_h))
                        && (32'(w_col) + 32'd1 >= 32'(w_w));

        n_row  = w_row;
        n_col  = CW'(32'(w_col) + 32'd1);
        n_slot = w_slot;
        if (32'(w_col) + 32'd1 >= 32'(w_w)) begin
            n_col  = '0;
            n_slot = (32'(w_slot) + 32'd1 == 32'(w_k)) ? '0 : SW'(32'(w_slot) + 32'd1);
            n_row  = (32'(w_row) + 32'd1 >= 32'(w_h)) ? '0 : RWD'(32'(w_row) + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
            r_act_r <= RDW'(RST_RADIUS);
            r_act_w <= RST_WIDTH;
            r_act_h <= RST_HEIGHT;
        end else if (o_push) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_slot  <= n_slot;
            r_act_r <= w_r;
            r_act_w <= w_w;
            r_act_h <= w_h;
        end
    end

endmodule

`default_nettype wire

// ----- design/lmvf_queue.sv -----
// Short request queue between the front and back parts.
// Depends on lmvf_pkg for the entry type.
`default_nettype none

module lmvf_queue #(
    parameter int DEPTH = lmvf_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  lmvf_pkg::t_item      i_item,
    input  wire logic            i_pop,
    output lmvf_pkg::t_item      o_item,
    output logic                 o_full,
    output logic                 o_empty
);
    import lmvf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_item          r_mem [0:DEPTH-1];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;

    assign o_full  = r_cnt == NW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= (32'(r_wr) == DEPTH - 1) ? '0 : PW'(32'(r_wr) + 32'd1);
            if (i_pop)
                r_rd <= (32'(r_rd) == DEPTH - 1) ? '0 : PW'(32'(r_rd) + 32'd1);
            if (i_push && !i_pop)
                r_cnt <= NW'(32'(r_cnt) + 32'd1);
            else if (i_pop && !i_push)
                r_cnt <= NW'(32'(r_cnt) - 32'd1);
        end
    end

endmodule

`default_nettype wire

// ----- design/lmvf_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on lmvf_pkg for widths.
`default_nettype none

module lmvf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lmvf_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [lmvf_pkg::DEN_W-1:0]  i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [lmvf_pkg::DIV_W-1:0]       o_quotient
);
    import lmvf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DEN_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial    = {r_rem[DEN_W-1:0], r_quo[DIV_W-1]};
    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && r_cnt == CNT_W'(1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1))
                    r_busy <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/lmvf_back.sv -----
// Back part: line store and column sums, window sums, mean/variance math
// and the result register. Depends on lmvf_pkg.
`default_nettype none

module lmvf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  lmvf_pkg::t_item                  i_item,
    output logic                             o_pop,
    input  wire logic [4:0]                  i_smooth,
    output logic                             o_div_start,
    output logic [lmvf_pkg::DIV_W-1:0]       o_div_dividend,
    output logic [lmvf_pkg::DEN_W-1:0]       o_div_divisor,
    input  wire logic                        i_div_done,
    input  wire logic [lmvf_pkg::DIV_W-1:0]  i_div_quotient,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [7:0]                       o_filtered,
    output logic [lmvf_pkg::RWD-1:0]         o_out_row,
    output logic [lmvf_pkg::CW-1:0]          o_out_col,
    output logic                             o_frame_last
);
    import lmvf_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_READ    = 4'd1;
    localparam logic [3:0] ST_UPD     = 4'd2;
    localparam logic [3:0] ST_MEAN_GO = 4'd3;
    localparam logic [3:0] ST_MEAN_W  = 4'd4;
    localparam logic [3:0] ST_MS      = 4'd5;
    localparam logic [3:0] ST_VAR_GO  = 4'd6;
    localparam logic [3:0] ST_VAR_W   = 4'd7;
    localparam logic [3:0] ST_PROD    = 4'd8;
    localparam logic [3:0] ST_Q1_GO   = 4'd9;
    localparam logic [3:0] ST_Q1_W    = 4'd10;
    localparam logic [3:0] ST_Q2_GO   = 4'd11;
    localparam logic [3:0] ST_Q2_W    = 4'd12;
    localparam logic [3:0] ST_OUT     = 4'd13;

    localparam int LS_DEPTH = 2 ** (SW + CW);

    logic [7:0]      r_line [0:LS_DEPTH-1];
    logic [CS_W-1:0] r_csum [0:MAX_COLS-1];
    logic [CQ_W-1:0] r_csq  [0:MAX_COLS-1];

    logic [3:0]         r_state;
    t_item              r_item;
    logic [7:0]         r_old, r_ctr_rd, r_centre;
    logic [CS_W-1:0]    r_cs_rd, r_csk_rd;
    logic [CQ_W-1:0]    r_cq_rd, r_cqk_rd;
    logic [WS_W-1:0]    r_ws;
    logic [WQ_W-1:0]    r_wq;
    logic [7:0]         r_mean;
    logic [DIV_W-1:0]   r_ms;
    logic [VAR_W-1:0]   r_var;
    logic [9:0]         r_lsq;
    logic [ALPHA_W-1:0] r_alpha;
    logic [DIV_W-1:0]   r_num1, r_num2;
    logic [DEN_W-1:0]   r_den;
    logic [7:0]         r_q1;
    logic [7:0]         r_f;
    logic               r_valid;

    logic [CS_W-1:0] w_cs_c, n_cs;
    logic [CQ_W-1:0] w_cq_c, n_cq;
    logic [15:0]     w_old_sq, w_pix_sq;
    logic [WS_W-1:0] n_ws;
    logic [WQ_W-1:0] n_wq;
    logic [DIV_W-1:0] w_wq_x;
    logic [8:0]      w_sum;
    logic            w_load;

    // column update (add the new pixel, drop the one k rows up) and window sums
    always_comb begin
        w_cs_c   = r_item.zero_col ? '0 : r_cs_rd;
        w_cq_c   = r_item.zero_col ? '0 : r_cq_rd;
        w_old_sq = {8'd0, r_old} * {8'd0, r_old};
        w_pix_sq = {8'd0, r_item.pix} * {8'd0, r_item.pix};
        n_cs = w_cs_c - (r_item.sub_old ? CS_W'(r_old) : '0) + CS_W'(r_item.pix);
        n_cq = w_cq_c - (r_item.sub_old ? CQ_W'(w_old_sq) : '0) + CQ_W'(w_pix_sq);
        n_ws = (r_item.first_col ? '0 : r_ws) + WS_W'(n_cs)
             - (r_item.use_k ? WS_W'(r_csk_rd) : '0);
        n_wq = (r_item.first_col ? '0 : r_wq) + WQ_W'(n_cq)
             - (r_item.use_k ? WQ_W'(r_cqk_rd) : '0);
    end

    always_comb begin
        w_wq_x         = DIV_W'(r_wq);
        o_div_start    = 1'b0;
        o_div_dividend = '0;
        o_div_divisor  = r_den;
        case (r_state)
            ST_MEAN_GO: begin
                o_div_start    = 1'b1;
                o_div_dividend = DIV_W'(r_ws);
                o_div_divisor  = DEN_W'(r_item.area);
            end
            ST_VAR_GO: begin
                o_div_start    = 1'b1;
                o_div_dividend = (w_wq_x > r_ms) ? w_wq_x - r_ms : '0;
                o_div_divisor  = DEN_W'(r_item.area);
            end
            ST_Q1_GO: begin
                o_div_start    = 1'b1;
                o_div_dividend = r_num1;
            end
            ST_Q2_GO: begin
                o_div_start    = 1'b1;
                o_div_dividend = r_num2;
            end
            default: begin
                o_div_start = 1'b0;
            end
        endcase
    end

    assign w_sum  = {1'b0, r_q1} + {1'b0, i_div_quotient[7:0]};
    assign o_pop  = r_state == ST_IDLE && !i_empty;
    assign w_load = r_state == ST_OUT && (!r_valid || !i_stall);

    // storage: reads every cycle at the current item's addresses, writes in ST_UPD
    always_ff @(posedge i_clk) begin
        r_old    <= r_line[{r_item.slot_old, r_item.col}];
        r_ctr_rd <= r_line[{r_item.cslot, r_item.col_r}];
        r_cs_rd  <= r_csum[r_item.col];
        r_csk_rd <= r_csum[r_item.col_k];
        r_cq_rd  <= r_csq[r_item.col];
        r_cqk_rd <= r_csq[r_item.col_k];
        if (r_state == ST_UPD) begin
            r_line[{r_item.slot_old, r_item.col}] <= r_item.pix;
            r_csum[r_item.col] <= n_cs;
            r_csq[r_item.col]  <= n_cq;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lsq   <= {5'd0, i_smooth} * {5'd0, i_smooth};
        r_alpha <= ALPHA_W'({r_lsq, 2'b00}) + ALPHA_W'(r_lsq) + ALPHA_W'(10);
        if (o_pop)
            r_item <= i_item;
        case (r_state)
            ST_UPD: r_centre <= r_ctr_rd;
            ST_MEAN_W: begin
                if (i_div_done)
                    r_mean <= i_div_quotient[7:0];
            end
            ST_MS: r_ms <= DIV_W'(r_mean) * DIV_W'(r_ws);
            ST_VAR_W: begin
                if (i_div_done)
                    r_var <= i_div_quotient[VAR_W-1:0];
            end
            ST_PROD: begin
                r_num1 <= DIV_W'(r_alpha) * DIV_W'(r_mean);
                r_num2 <= DIV_W'(r_var) * DIV_W'(r_centre);
                r_den  <= DEN_W'(r_var) + DEN_W'(r_alpha);
            end
            ST_Q1_W: begin
                if (i_div_done)
                    r_q1 <= i_div_quotient[7:0];
            end
            ST_Q2_W: begin
                if (i_div_done)
                    r_f <= w_sum[8] ? 8'hFF : w_sum[7:0];
            end
            default: begin
            end
        endcase
        if (w_load) begin
            o_filtered   <= r_f;
            o_out_row    <= r_item.out_row;
            o_out_col    <= r_item.col_r;
            o_frame_last <= r_item.last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_ws    <= '0;
            r_wq    <= '0;
        end else begin
            if (w_load)
                r_valid <= 1'b1;
            else if (!i_stall)
                r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty)
                        r_state <= ST_READ;
                end
                ST_READ: r_state <= ST_UPD;
                ST_UPD: begin
                    r_ws    <= n_ws;
                    r_wq    <= n_wq;
                    r_state <= r_item.emit ? ST_MEAN_GO : ST_IDLE;
                end
                ST_MEAN_GO: r_state <= ST_MEAN_W;
                ST_MEAN_W: begin
                    if (i_div_done)
                        r_state <= ST_MS;
                end
                ST_MS:     r_state <= ST_VAR_GO;
                ST_VAR_GO: r_state <= ST_VAR_W;
                ST_VAR_W: begin
                    if (i_div_done)
                        r_state <= ST_PROD;
                end
                ST_PROD:  r_state <= ST_Q1_GO;
                ST_Q1_GO: r_state <= ST_Q1_W;
                ST_Q1_W: begin
                    if (i_div_done)
                        r_state <= ST_Q2_GO;
                end
                ST_Q2_GO: r_state <= ST_Q2_W;
                ST_Q2_W: begin
                    if (i_div_done)
                        r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_load)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ----- design/local_mean_variance_filter_core.sv -----
// Top level of the local mean/variance smoothing filter.
// Depends on lmvf_pkg, lmvf_front, lmvf_queue, lmvf_div, lmvf_back
// and local_mean_variance_filter_core_assert.svh.
//
// Usage:
//  - Input channel: i_in_valid / o_in_stall carry one pixel request
//    (i_pixel, i_frame_start) in raster order. A request is taken on an edge
//    with valid high and stall low.
//  - Output channel: o_out_valid / i_out_stall carry one result per interior
//    pixel (o_filtered, o_out_row, o_out_col, o_frame_last). Border pixels
//    give no result.
//  - Config: i_cfg_we writes i_cfg_data into register i_cfg_addr
//    (0 radius, 1 smooth level, 2 width, 3 height). Radius and frame size
//    are sampled at each frame start; smooth level acts at once.
//  - Flow: a pixel that makes no result passes the back part through its
//    idle, read and update states; one that makes a result also waits on
//    the four quotients that share one bit-per-cycle divider. The front
//    keeps taking pixels into a FIFO_DEPTH-entry queue meanwhile and stalls
//    when it is full.
//  - Reset: synchronous, active low. Registers return to their defaults,
//    the queue empties and the next pixel starts a frame.
//  - When the receiver stalls, the result register holds; the back part
//    waits with its next result until the register is taken.
`default_nettype none

module local_mean_variance_filter_core #(
    parameter int FIFO_DEPTH = lmvf_pkg::QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_pixel,
    input  wire logic                        i_frame_start,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_filtered,
    output logic [lmvf_pkg::RWD-1:0]         o_out_row,
    output logic [lmvf_pkg::CW-1:0]          o_out_col,
    output logic                             o_frame_last,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_addr,
    input  wire logic [lmvf_pkg::CFG_W-1:0]  i_cfg_data
);
    import lmvf_pkg::*;

    `include "local_mean_variance_filter_core_assert.svh"

    // configuration registers
    logic [3:0]       r_radius;
    logic [4:0]       r_smooth;
    logic [CFG_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RST_RADIUS;
            r_smooth <= RST_SMOOTH;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RADIUS: r_radius <= i_cfg_data[3:0];
                REG_SMOOTH: r_smooth <= i_cfg_data[4:0];
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    t_item            w_push_item, w_head;
    logic             w_push, w_pop, w_q_full, w_q_empty;
    logic             w_div_start, w_div_busy, w_div_done;
    logic [DIV_W-1:0] w_div_dvd, w_div_quo;
    logic [DEN_W-1:0] w_div_dsr;

    assign o_in_stall = w_q_full;

    // front: position tracking and classification of each pixel
    lmvf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_full        (w_q_full),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_radius      (r_radius),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    lmvf_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    lmvf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // back: line store, sums and the filter arithmetic
    lmvf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_q_empty),
        .i_item         (w_head),
        .o_pop          (w_pop),
        .i_smooth       (r_smooth),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dvd),
        .o_div_divisor  (w_div_dsr),
        .i_div_done     (w_div_done),
        .i_div_quotient (w_div_quo),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_filtered     (o_filtered),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_frame_last   (o_frame_last)
    );

    `LMVF_CHK_NOW(a_pop_nonempty, w_pop, !w_q_empty, "pop from empty queue")
    `LMVF_CHK_NEXT(a_push_fills, w_push && w_q_empty, !w_q_empty, "push lost")
    `LMVF_CHK_NOW(a_div_free, w_div_start, !w_div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

// ----- tb/local_mean_variance_filter_core_tb.sv -----
// Self-checking testbench for local_mean_variance_filter_core.
// Needs lmvf_pkg and the core; a scoreboard class predicts each result from accepted pixels.
`timescale 1ns / 1ps

typedef struct packed {
    bit [7:0]               filtered;
    bit [lmvf_pkg::RWD-1:0] row;
    bit [lmvf_pkg::CW-1:0]  col;
    bit                     last;
} t_lmvf_result;

class lmvf_scoreboard;
    // register mirror
    bit [3:0]  radius_reg;
    bit [4:0]  smooth_reg;
    bit [11:0] width_reg;
    bit [11:0] height_reg;
    // values latched at frame start
    int unsigned r_act, w_act, h_act, slot;
    bit [7:0]    lines[lmvf_pkg::SLOTS][lmvf_pkg::MAX_COLS];
    int unsigned col_sum[lmvf_pkg::MAX_COLS];
    int unsigned col_sq[lmvf_pkg::MAX_COLS];
    int unsigned win_sum, win_sq, row_cnt, col_cnt;
    t_lmvf_result pending[$];
    int mismatches;

    function new();
        radius_reg = lmvf_pkg::RST_RADIUS;
        smooth_reg = lmvf_pkg::RST_SMOOTH;
        width_reg  = lmvf_pkg::RST_WIDTH;
        height_reg = lmvf_pkg::RST_HEIGHT;
        r_act = 2; w_act = 640; h_act = 480; slot = 0;
        win_sum = 0; win_sq = 0; row_cnt = 0; col_cnt = 0;
        mismatches = 0;
        foreach (col_sum[i]) begin
            col_sum[i] = 0;
            col_sq[i]  = 0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] data);
        case (idx)
            lmvf_pkg::REG_RADIUS: radius_reg = data[3:0];
            lmvf_pkg::REG_SMOOTH: smooth_reg = data[4:0];
            lmvf_pkg::REG_WIDTH:  width_reg  = data;
            lmvf_pkg::REG_HEIGHT: height_reg = data;
            default: ;
        endcase
    endfunction

    static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Runs one accepted pixel request through the filter and queues any result.
    function void note_request(bit [7:0] pix, bit fs);
        int unsigned k, c, old, cslot;
        longint unsigned area, s, q, mean, ms, variance, alpha, centre, f;
        t_lmvf_result res;
        if (fs || (row_cnt == 0 && col_cnt == 0)) begin
            row_cnt = 0; col_cnt = 0; slot = 0;
            r_act = clamp(radius_reg, 1, lmvf_pkg::MAX_RADIUS);
            w_act = clamp(width_reg, 3, lmvf_pkg::MAX_COLS);
            h_act = clamp(height_reg, 3, lmvf_pkg::MAX_ROWS);
            foreach (col_sum[i]) begin
                col_sum[i] = 0;
                col_sq[i]  = 0;
            end
        end
        k = 2 * r_act + 1;
        c = col_cnt;
        // vertical: add new pixel, drop the one k rows up
        if (row_cnt >= k) begin
            old = lines[slot][c];
            col_sum[c] -= old;
            col_sq[c]  -= old * old;
        end
        col_sum[c] += pix;
        col_sq[c]  += pix * pix;
        lines[slot][c] = pix;
        // horizontal running sums
        if (c == 0) begin
            win_sum = 0;
            win_sq  = 0;
        end
        win_sum += col_sum[c];
        win_sq  += col_sq[c];
        if (c >= k) begin
            win_sum -= col_sum[c - k];
            win_sq  -= col_sq[c - k];
        end
        if (row_cnt >= 2 * r_act && c >= 2 * r_act) begin
            area     = k * k;
            s        = win_sum;
            q        = win_sq;
            mean     = s / area;
            ms       = mean * s;
            variance = ((q > ms) ? q - ms : 0) / area;
            alpha    = 5 * smooth_reg * smooth_reg + 10;
            cslot    = (slot + k - r_act) % k;
            centre   = lines[cslot][c - r_act];
            f = alpha * mean / (variance + alpha) + variance * centre / (variance + alpha);
            res.filtered = (f > 255) ? 8'd255 : f[7:0];
            res.row  = lmvf_pkg::RWD'(row_cnt - r_act);
            res.col  = lmvf_pkg::CW'(c - r_act);
            res.last = (row_cnt + 1 >= h_act) && (c + 1 >= w_act);
            pending.push_back(res);
        end
        col_cnt = c + 1;
        if (col_cnt >= w_act) begin
            col_cnt = 0;
            row_cnt++;
            slot = (slot + 1) % k;
            if (row_cnt >= h_act) row_cnt = 0;
        end
    endfunction

    function void check_result(t_lmvf_result got);
        t_lmvf_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result f=%0d row=%0d col=%0d last=%0b",
                         got.filtered, got.row, got.col, got.last);
            return;
        end
        want = pending.pop_front();
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: exp f=%0d row=%0d col=%0d last=%0b",
                         want.filtered, want.row, want.col, want.last);
                $display("       got f=%0d row=%0d col=%0d last=%0b",
                         got.filtered, got.row, got.col, got.last);
            end
        end
    endfunction
endclass

module local_mean_variance_filter_core_tb;
    import lmvf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int LONG_HOLD      = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_pixel = '0;
    logic                i_frame_start = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [7:0]          o_filtered;
    logic [RWD-1:0]      o_out_row;
    logic [CW-1:0]       o_out_col;
    logic                o_frame_last;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_addr = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    lmvf_scoreboard sb = new();

    bit idle_on = 1'b1;     // random gaps on both sides
    bit long_hold_req = 1'b0;
    int idle_cycles = 0;
    int n_sent = 0;

    always #6 i_clk = ~i_clk;

    local_mean_variance_filter_core dut (.*);

    // Receiver: checks each accepted result, then draws its own stall.
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        t_lmvf_result got;
        bit taken;
        taken = i_rst_n && o_out_valid && !i_out_stall;
        if (taken) begin
            got.filtered = o_filtered;
            got.row      = o_out_row;
            got.col      = o_out_col;
            got.last     = o_frame_last;
            sb.check_result(got);
        end
        if (hold_cnt > 0)
            hold_cnt--;
        else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
        end else if (taken && idle_on)
            hold_cnt = $urandom_range(0, 4);
        i_out_stall <= (hold_cnt > 0);
    end

    // Watchdog on cycles without any request moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one pixel request, holds it until taken, then maybe idles.
    task automatic send_pixel(bit [7:0] pix, bit fs);
        int gap;
        i_in_valid    <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(pix, fs);
        n_sent++;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender pause: all results back, then idles so result-free pixels still queued pass through.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int r, int s, int w, int h);
        write_reg(REG_RADIUS, CFG_W'(r));
        write_reg(REG_SMOOTH, CFG_W'(s));
        write_reg(REG_WIDTH,  CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
    endtask

    // style 0 (and any other): uniform noise, 1: flat patch with small ripple, 2: black/white only
    function automatic bit [7:0] pick_pixel(int style, int base);
        int v;
        case (style)
            1: begin
                v = base + $urandom_range(0, 6) - 3;
                return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
            end
            2:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends whole frames; some are cut short, and the next one then carries frame_start.
    // cap limits pixels per frame (0 = whole frame).
    task automatic run_frames(int frames, int cap);
        int w, h, len, style, base;
        bit cut;
        w   = sb.clamp(sb.width_reg, 3, MAX_COLS);
        h   = sb.clamp(sb.height_reg, 3, MAX_ROWS);
        cut = 1'b1;     // first frame of a phase always marked
        for (int f = 0; f < frames; f++) begin
            len = w * h;
            if (cap > 0 && len > cap) len = cap;
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 255);
            for (int p = 0; p < len; p++)
                send_pixel(pick_pixel(style, base),
                           (p == 0) && (cut || $urandom_range(0, 1) != 0));
            cut = (cap > 0 && len < w * h);
            if (!cut && $urandom_range(0, 9) == 0) begin
                // broken frame: a short run, then a fresh frame_start
                repeat ($urandom_range(1, w * h - 1))
                    send_pixel(pick_pixel(0, 0), 1'b0);
                cut = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x3 frames, flat black, flat white at max smoothing,
        // checkerboard (max variance) at min smoothing.
        configure(1, 31, 3, 3);
        for (int p = 0; p < 9; p++) send_pixel(8'd0, p == 0);
        for (int p = 0; p < 9; p++) send_pixel(8'd255, 1'b0);
        drain();
        write_reg(REG_SMOOTH, CFG_W'(0));
        for (int p = 0; p < 9; p++) send_pixel((p % 2) ? 8'd255 : 8'd0, p == 0);
        drain();

        // Radius 0 acts as 1, size 0 clamps to 3; frame smaller than window gives nothing.
        configure(0, 7, 0, 0);
        run_frames(3, 0);
        drain();
        configure(3, 12, 5, 5);
        run_frames(2, 0);
        drain();

        // Long receiver hold with back-to-back input: queue fills, input stalls.
        idle_on = 1'b0;
        configure(1, 3, 8, 6);
        long_hold_req = 1'b1;
        run_frames(2, 0);
        drain();
        idle_on = 1'b1;

        // Largest radius on a frame that just fits its window (31 wide, 32 tall).
        configure(15, 31, 31, 32);
        run_frames(1, 0);
        drain();

        // Widest frame, masked upper data bits on radius and smooth level, cut short.
        configure(12'hFF1, 12'hFF4, 12'hFFF, 3);
        run_frames(1, 100);
        drain();

        // Tallest frame, cut short.
        configure(2, 20, 5, 4095);
        run_frames(1, 200);
        drain();

        while (n_sent < 1900) begin
            int r, w, h, n;
            r = $urandom_range(1, 3);
            w = $urandom_range(2 * r + 1, 2 * r + 6);
            h = $urandom_range(2 * r + 1, 2 * r + 4);
            if ($urandom_range(0, 7) == 0) w = $urandom_range(3, 2 * r);
            n = $urandom_range(1, 2);
            idle_on = ($urandom_range(0, 3) != 0);
            configure(r, $urandom_range(0, 31), w, h);
            run_frames(n, 0);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
